>>> hw/rtl/hgbs_pkg.sv
// hgbs_pkg: shared types, constants and helpers for the height-grid sampler
// depends on nothing; imported by every module of the sampler
package hgbs_pkg;

   // fixed field widths
   localparam int COORD_BITS  = 24;
   localparam int SAMPLE_BITS = 16;
   localparam int POS_BITS    = 6;
   localparam int SIZE_BITS   = 7;
   localparam int FRAC_BITS   = 17;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 24;

   // grid limits
   localparam logic [SIZE_BITS-1:0] MAX_COLS = 7'd64;
   localparam logic [SIZE_BITS-1:0] MAX_ROWS = 7'd64;
   localparam logic [SIZE_BITS-1:0] MIN_SIZE = 7'd2;

   // one in 16-bit fixed point
   localparam logic [FRAC_BITS-1:0] ONE_Q16 = 17'h10000;

   // item kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WRAP_MODE     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEIGHT_SCALE  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEIGHT_OFFSET = 3'd4;

   typedef struct packed {
      logic                           req_type;
      logic [POS_BITS-1:0]            write_col;
      logic [POS_BITS-1:0]            write_row;
      logic signed [SAMPLE_BITS-1:0]  write_value;
      logic signed [COORD_BITS-1:0]   coord_x;
      logic signed [COORD_BITS-1:0]   coord_y;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] height;
      logic signed [39:0] grad_x;
      logic signed [39:0] grad_y;
   } rsp_item_type;

   // located item between the coordinate stages and the memory stage
   typedef struct packed {
      logic                           valid;
      logic                           query;
      logic [POS_BITS-1:0]            col;
      logic [POS_BITS-1:0]            row;
      logic signed [SAMPLE_BITS-1:0]  value;
      logic [POS_BITS-1:0]            ix;
      logic [POS_BITS-1:0]            iy;
      logic [FRAC_BITS-1:0]           s;
      logic [FRAC_BITS-1:0]           t;
   } loc_type;

   // size register limited to [2, max], returned as size - 1
   function automatic logic [SIZE_BITS-1:0] size_m1(input logic [SIZE_BITS-1:0] sz,
                                                    input logic [SIZE_BITS-1:0] mx);
      logic [SIZE_BITS-1:0] v;
      v = sz;
      if (v < MIN_SIZE) v = MIN_SIZE;
      if (v > mx) v = mx;
      return v - 7'd1;
   endfunction

endpackage

>>> hw/rtl/hgbs_bank.sv
// hgbs_bank: one bank of the grid store, one write and one registered read port
// depends on hgbs_pkg
module hgbs_bank import hgbs_pkg::*; (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [9:0]                    wr_addr,
   input  logic signed [SAMPLE_BITS-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [9:0]                    rd_addr,
   output logic signed [SAMPLE_BITS-1:0] rd_data
);

   logic signed [SAMPLE_BITS-1:0] mem [1024];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, held while the pipe stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/hgbs_locate.sv
// hgbs_locate: two stages mapping query coordinates to cell index and fraction
// depends on hgbs_pkg
module hgbs_locate import hgbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  req_item_type         in_item,
   input  logic                 wrap_mode,
   input  logic [SIZE_BITS-1:0] wm1,
   input  logic [SIZE_BITS-1:0] hm1,
   output loc_type              loc
);

   logic                 valid_a_ff;
   req_item_type         item_a_ff;
   logic [FRAC_BITS-1:0] ux_a_ff, uy_a_ff;
   logic [FRAC_BITS-1:0] ux_in, uy_in;
   loc_type              loc_ff, loc_in;

   // wrap to fraction or clamp to unit range
   function automatic logic [FRAC_BITS-1:0] to_unit(input logic signed [COORD_BITS-1:0] c,
                                                    input logic wrap);
      logic [FRAC_BITS-1:0] u;
      if (wrap) u = {1'b0, c[15:0]};
      else if (c < 0) u = '0;
      else if (c > 24'sd65536) u = ONE_Q16;
      else u = c[FRAC_BITS-1:0];
      return u;
   endfunction

   // scale by size - 1, split into index and fraction
   function automatic logic [POS_BITS+FRAC_BITS-1:0] split(input logic [FRAC_BITS-1:0] u,
                                                          input logic [SIZE_BITS-1:0] m1);
      logic [23:0] f;
      logic [7:0]  i;
      logic [7:0]  lim;
      logic [23:0] fr;
      f   = 24'(u) * 24'(m1);
      lim = 8'(m1) - 8'd1;
      i   = f[23:16];
      if (i > lim) i = lim;
      fr  = f - {i, 16'h0000};
      return {i[POS_BITS-1:0], fr[FRAC_BITS-1:0]};
   endfunction

   assign ux_in = to_unit(in_item.coord_x, wrap_mode);
   assign uy_in = to_unit(in_item.coord_y, wrap_mode);

   // stage a: unit coordinates
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_a_ff <= in_item;
         ux_a_ff   <= ux_in;
         uy_a_ff   <= uy_in;
      end
   end

   // stage b: cell index and fraction
   always_comb begin
      loc_in.valid      = valid_a_ff;
      loc_in.query      = (item_a_ff.req_type == REQ_QUERY);
      loc_in.col        = item_a_ff.write_col;
      loc_in.row        = item_a_ff.write_row;
      loc_in.value      = item_a_ff.write_value;
      {loc_in.ix, loc_in.s} = split(ux_a_ff, wm1);
      {loc_in.iy, loc_in.t} = split(uy_a_ff, hm1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loc_ff.valid <= 1'b0;
      end else if (en) begin
         loc_ff.valid <= loc_in.valid;
      end
      if (en) begin
         loc_ff.query <= loc_in.query;
         loc_ff.col   <= loc_in.col;
         loc_ff.row   <= loc_in.row;
         loc_ff.value <= loc_in.value;
         loc_ff.ix    <= loc_in.ix;
         loc_ff.iy    <= loc_in.iy;
         loc_ff.s     <= loc_in.s;
         loc_ff.t     <= loc_in.t;
      end
   end

   assign loc = loc_ff;

endmodule

>>> hw/rtl/hgbs_interp.sv
// hgbs_interp: weight, product, sum, scale and saturate stages of a query
// depends on hgbs_pkg; bank read data is registered from loc, in step with stage c
module hgbs_interp import hgbs_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  loc_type                       loc,
   input  logic signed [SAMPLE_BITS-1:0] bank_data [4],
   input  logic [SIZE_BITS-1:0]          wm1,
   input  logic [SIZE_BITS-1:0]          hm1,
   input  logic signed [15:0]            scale,
   input  logic signed [23:0]            offset,
   output logic                          out_valid,
   output rsp_item_type                  out_item
);

   // stage c: weights
   logic                 vc_ff;
   logic                 i0_c_ff, j0_c_ff;
   logic [32:0]          w00_c_ff, w01_c_ff, w10_c_ff, w11_c_ff;
   logic [FRAC_BITS-1:0] s_c_ff, t_c_ff, oms_c_ff, omt_c_ff;
   logic [FRAC_BITS-1:0] oms_in, omt_in;

   assign oms_in = ONE_Q16 - loc.s;
   assign omt_in = ONE_Q16 - loc.t;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (en) begin
         vc_ff <= loc.valid && loc.query;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         i0_c_ff  <= loc.ix[0];
         j0_c_ff  <= loc.iy[0];
         w00_c_ff <= 33'(oms_in) * 33'(omt_in);
         w01_c_ff <= 33'(loc.s) * 33'(omt_in);
         w10_c_ff <= 33'(oms_in) * 33'(loc.t);
         w11_c_ff <= 33'(loc.s) * 33'(loc.t);
         s_c_ff   <= loc.s;
         t_c_ff   <= loc.t;
         oms_c_ff <= oms_in;
         omt_c_ff <= omt_in;
      end
   end

   // stage d: pick samples out of the banks, products
   logic signed [SAMPLE_BITS-1:0] v00, v01, v10, v11;
   logic signed [16:0] dx0, dx1, dy0, dy1;
   logic signed [49:0] p00_in, p01_in, p10_in, p11_in;
   logic signed [34:0] gx0_in, gx1_in, gy0_in, gy1_in;
   logic               vd_ff;
   logic signed [49:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [34:0] gx0_ff, gx1_ff, gy0_ff, gy1_ff;

   assign v00 = bank_data[{j0_c_ff, i0_c_ff}];
   assign v01 = bank_data[{j0_c_ff, ~i0_c_ff}];
   assign v10 = bank_data[{~j0_c_ff, i0_c_ff}];
   assign v11 = bank_data[{~j0_c_ff, ~i0_c_ff}];

   assign dx0 = 17'(v01) - 17'(v00);
   assign dx1 = 17'(v11) - 17'(v10);
   assign dy0 = 17'(v10) - 17'(v00);
   assign dy1 = 17'(v11) - 17'(v01);

   assign p00_in = $signed({1'b0, w00_c_ff}) * v00;
   assign p01_in = $signed({1'b0, w01_c_ff}) * v01;
   assign p10_in = $signed({1'b0, w10_c_ff}) * v10;
   assign p11_in = $signed({1'b0, w11_c_ff}) * v11;
   assign gx0_in = $signed({1'b0, omt_c_ff}) * dx0;
   assign gx1_in = $signed({1'b0, t_c_ff}) * dx1;
   assign gy0_in = $signed({1'b0, oms_c_ff}) * dy0;
   assign gy1_in = $signed({1'b0, s_c_ff}) * dy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (en) begin
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p10_ff <= p10_in;
         p11_ff <= p11_in;
         gx0_ff <= gx0_in;
         gx1_ff <= gx1_in;
         gy0_ff <= gy0_in;
         gy1_ff <= gy1_in;
      end
   end

   // stage e: sums, height rounded to 1/256 units
   logic signed [50:0] sum_in;
   logic               ve_ff;
   logic signed [23:0] hq_ff;
   logic signed [35:0] dds_ff, ddt_ff;

   assign sum_in = 51'(p00_ff) + 51'(p01_ff) + 51'(p10_ff) + 51'(p11_ff) + 51'sd8388608;

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (en) begin
         ve_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hq_ff  <= 24'(sum_in >>> 24);
         dds_ff <= 36'(gx0_ff) + 36'(gx1_ff);
         ddt_ff <= 36'(gy0_ff) + 36'(gy1_ff);
      end
   end

   // stage f: height times scale, gradients times cell count
   logic               vf_ff;
   logic signed [39:0] hs_ff;
   logic signed [43:0] gxp_ff, gyp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
      end else if (en) begin
         vf_ff <= ve_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hs_ff  <= 40'(hq_ff) * 40'(scale);
         gxp_ff <= 44'(dds_ff) * $signed({37'd0, wm1});
         gyp_ff <= 44'(ddt_ff) * $signed({37'd0, hm1});
      end
   end

   // stage g: round, add offset; the height sum stays inside 32 bits
   logic               vg_ff;
   logic signed [31:0] ht_g_ff;
   logic signed [35:0] gx1r_ff, gy1r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vg_ff <= 1'b0;
      end else if (en) begin
         vg_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ht_g_ff <= 32'((hs_ff + 40'sd128) >>> 8) + 32'(offset);
         gx1r_ff <= 36'((gxp_ff + 44'sd128) >>> 8);
         gy1r_ff <= 36'((gyp_ff + 44'sd128) >>> 8);
      end
   end

   // stage h: gradients times scale
   logic               vh_ff;
   logic signed [31:0] ht_h_ff;
   logic signed [51:0] gx2_ff, gy2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vh_ff <= 1'b0;
      end else if (en) begin
         vh_ff <= vg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ht_h_ff <= ht_g_ff;
         gx2_ff  <= 52'(gx1r_ff) * 52'(scale);
         gy2_ff  <= 52'(gy1r_ff) * 52'(scale);
      end
   end

   // stage i: final rounding and saturation into the output register
   function automatic logic signed [39:0] sat40(input logic signed [51:0] p);
      logic signed [43:0] r;
      r = 44'((p + 52'sd128) >>> 8);
      if (r > 44'sd549755813887) return 40'sh7F_FFFF_FFFF;
      if (r < -44'sd549755813888) return 40'sh80_0000_0000;
      return r[39:0];
   endfunction

   logic         out_valid_ff;
   rsp_item_type out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= vh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_item_ff.height <= ht_h_ff;
         out_item_ff.grad_x <= sat40(gx2_ff);
         out_item_ff.grad_y <= sat40(gy2_ff);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

>>> hw/rtl/height_grid_bilinear_sampler_unit.sv
// height_grid_bilinear_sampler_unit: top level of the height-grid sampler
// a query's result passes locate stages a and b and interp stages c to i; writes give none
// throughput: one item per cycle; the whole pipe holds while rsp_valid waits on rsp_ready
// the grid store is four parity banks so the four corner samples come from one read each
// reset clears valid bits and sets config registers to their defaults; the grid store is not cleared
// depends on hgbs_pkg, hgbs_locate, hgbs_bank, hgbs_interp
module height_grid_bilinear_sampler_unit import hgbs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_item_type             req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_item_type             rsp_item,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // config registers
   logic [SIZE_BITS-1:0] grid_width_ff, grid_height_ff;
   logic                 wrap_mode_ff;
   logic signed [15:0]   height_scale_ff;
   logic signed [23:0]   height_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff    <= 7'd64;
         grid_height_ff   <= 7'd64;
         wrap_mode_ff     <= 1'b0;
         height_scale_ff  <= 16'sd256;
         height_offset_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:    grid_width_ff    <= csr_wdata[SIZE_BITS-1:0];
            CSR_GRID_HEIGHT:   grid_height_ff   <= csr_wdata[SIZE_BITS-1:0];
            CSR_WRAP_MODE:     wrap_mode_ff     <= csr_wdata[0];
            CSR_HEIGHT_SCALE:  height_scale_ff  <= csr_wdata[15:0];
            CSR_HEIGHT_OFFSET: height_offset_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   logic [SIZE_BITS-1:0] wm1, hm1;
   assign wm1 = size_m1(grid_width_ff, MAX_COLS);
   assign hm1 = size_m1(grid_height_ff, MAX_ROWS);

   // global advance: move when the output register is empty or taken
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   loc_type loc;

   hgbs_locate u_locate (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_item   (req_item),
      .wrap_mode (wrap_mode_ff),
      .wm1       (wm1),
      .hm1       (hm1),
      .loc       (loc)
   );

   // bank addressing: bank {row parity, col parity}, entry {row/2, col/2}
   logic [POS_BITS-1:0] ix1, iy1;
   logic                wr_go;
   logic [1:0]          wr_bank;
   logic signed [SAMPLE_BITS-1:0] bank_data [4];

   assign ix1     = loc.ix + 6'd1;
   assign iy1     = loc.iy + 6'd1;
   assign wr_go   = en && loc.valid && !loc.query;
   assign wr_bank = {loc.row[0], loc.col[0]};

   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic [1:0] BANK_SEL = 2'(b);
      logic [4:0] ra, ca;
      assign ra = BANK_SEL[1] ? loc.iy[5:1] : iy1[5:1];
      assign ca = BANK_SEL[0] ? loc.ix[5:1] : ix1[5:1];

      hgbs_bank u_bank (
         .clock   (clock),
         .wr_en   (wr_go && (wr_bank == BANK_SEL)),
         .wr_addr ({loc.row[5:1], loc.col[5:1]}),
         .wr_data (loc.value),
         .rd_en   (en),
         .rd_addr ({ra, ca}),
         .rd_data (bank_data[b])
      );
   end

   hgbs_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .loc       (loc),
      .bank_data (bank_data),
      .wm1       (wm1),
      .hm1       (hm1),
      .scale     (height_scale_ff),
      .offset    (height_offset_ff),
      .out_valid (rsp_valid),
      .out_item  (rsp_item)
   );

   // located cell stays inside the grid in use
   assert property (@(posedge clock) disable iff (reset)
      loc.valid && loc.query |->
         (7'(loc.ix) < wm1) && (7'(loc.iy) < hm1) && (loc.s <= ONE_Q16) && (loc.t <= ONE_Q16))
      else $error("located cell out of grid");

   // a stall freezes the located stage
   assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(loc))
      else $error("locate stage moved during stall");

   // no result right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

>>> bench/height_grid_bilinear_sampler_unit_test.sv
// height_grid_bilinear_sampler_unit_test: self-checking bench for the height-grid sampler
// predicts each query result from its own grid and register copy; depends on hgbs_pkg
module height_grid_bilinear_sampler_unit_test;
   import hgbs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS = int'(MAX_COLS);
   localparam int ROWS = int'(MAX_ROWS);
   localparam longint UNIT = 64'sd65536;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED_INDEX = CSR_HEIGHT_OFFSET + 3'd1;
   localparam int REQ_BITS = $bits(req_item_type);
   // loaded region: a square block in the corner plus two full rows and two full columns
   localparam int BLOCK = 20;
   localparam int STRIP = 2;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   req_item_type req_item;
   rsp_item_type rsp_item;
   logic csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   // mirrored state
   shortint grid_mirror [COLS*ROWS];
   logic [6:0] cfg_width, cfg_height;
   logic cfg_wrap;
   logic signed [15:0] cfg_scale;
   logic signed [23:0] cfg_offset;

   rsp_item_type pending_samples [$];
   int mismatches = 0;
   bit send_idle = 1, recv_idle = 1;

   height_grid_bilinear_sampler_unit dut (.*);

   // clock
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic longint round_half_up(longint v, int k);
      return (v + (64'sd1 << (k - 1))) >>> k;
   endfunction

   function automatic longint clip(longint v, int bits);
      longint hi, lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic int used_size(logic [6:0] sz, int mx);
      int v;
      v = int'(sz);
      if (v < 2) v = 2;
      if (v > mx) v = mx;
      return v;
   endfunction

   // coordinate to cell index and 16-bit fraction
   function automatic void locate_cell(input logic signed [23:0] c, input int size,
                                       output longint idx, output longint frac);
      longint u, f, i;
      if (cfg_wrap) u = longint'(c) & (UNIT - 1);
      else if (c < 0) u = 0;
      else if (longint'(c) > UNIT) u = UNIT;
      else u = longint'(c);
      f = u * (size - 1);
      i = f >>> 16;
      if (i > size - 2) i = size - 2;
      idx = i;
      frac = f - (i <<< 16);
   endfunction

   function automatic rsp_item_type sample_height(req_item_type q);
      rsp_item_type r;
      int w, h;
      longint i, j, s, t, base, v00, v01, v10, v11, sum, hq, ht, dds, ddt, gx, gy;
      w = used_size(cfg_width, COLS);
      h = used_size(cfg_height, ROWS);
      locate_cell(q.coord_x, w, i, s);
      locate_cell(q.coord_y, h, j, t);
      base = j * COLS + i;
      v00 = grid_mirror[base];
      v01 = grid_mirror[base + 1];
      v10 = grid_mirror[base + COLS];
      v11 = grid_mirror[base + COLS + 1];
      sum = (UNIT - s) * (UNIT - t) * v00 + s * (UNIT - t) * v01
          + (UNIT - s) * t * v10 + s * t * v11;
      hq = round_half_up(sum, 24);
      ht = round_half_up(hq * longint'(cfg_scale), 8) + longint'(cfg_offset);
      dds = (UNIT - t) * (v01 - v00) + t * (v11 - v10);
      ddt = (UNIT - s) * (v10 - v00) + s * (v11 - v01);
      gx = round_half_up(round_half_up(dds * (w - 1), 8) * longint'(cfg_scale), 8);
      gy = round_half_up(round_half_up(ddt * (h - 1), 8) * longint'(cfg_scale), 8);
      r.height = clip(ht, 32);
      r.grad_x = clip(gx, 40);
      r.grad_y = clip(gy, 40);
      return r;
   endfunction

   // track accepted items and register writes, check results
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_WIDTH:    cfg_width  = csr_wdata[6:0];
               CSR_GRID_HEIGHT:   cfg_height = csr_wdata[6:0];
               CSR_WRAP_MODE:     cfg_wrap   = csr_wdata[0];
               CSR_HEIGHT_SCALE:  cfg_scale  = csr_wdata[15:0];
               CSR_HEIGHT_OFFSET: cfg_offset = csr_wdata[23:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_item.req_type == REQ_QUERY)
               pending_samples.push_back(sample_height(req_item));
            else
               grid_mirror[int'(req_item.write_row) * COLS + int'(req_item.write_col)] =
                  req_item.write_value;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_samples.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_item);
            end else begin
               want = pending_samples.pop_front();
               if (rsp_item.height !== want.height || rsp_item.grad_x !== want.grad_x ||
                   rsp_item.grad_y !== want.grad_y) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected h=%0d gx=%0d gy=%0d got h=%0d gx=%0d gy=%0d",
                              want.height, want.grad_x, want.grad_y,
                              rsp_item.height, rsp_item.grad_x, rsp_item.grad_y);
               end
            end
         end
      end
   end

   // result side stalls in bursts while recv_idle is set
   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (recv_idle && $urandom_range(0, 9) == 0) begin
            rsp_ready = 0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_ready = 1;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input req_item_type it);
      if (send_idle && $urandom_range(0, 7) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_item = it;
      req_valid = 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic write_sample(input int col, input int row, input logic [15:0] v);
      req_item_type it;
      it = req_item_type'(REQ_BITS'({$urandom, $urandom, $urandom}));
      it.req_type = REQ_WRITE;
      it.write_col = 6'(col);
      it.write_row = 6'(row);
      it.write_value = v;
      send_item(it);
   endtask

   task automatic query_at(input logic [23:0] x, input logic [23:0] y);
      req_item_type it;
      it = req_item_type'(REQ_BITS'({$urandom, $urandom, $urandom}));
      it.req_type = REQ_QUERY;
      it.coord_x = x;
      it.coord_y = y;
      send_item(it);
   endtask

   function automatic logic [23:0] pick_coord();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return 24'($urandom_range(0, 65536));
         4: return 24'($urandom_range(0, 3));
         5: return 24'(65536 - $urandom_range(0, 3) + $urandom_range(0, 3));
         default: return 24'($urandom);
      endcase
   endfunction

   // grid sizes whose queries only touch the loaded region
   function automatic void pick_sizes(output logic [6:0] w, output logic [6:0] h);
      case ($urandom_range(0, 2))
         0: begin
            w = 7'($urandom_range(0, 127));
            h = 7'($urandom_range(0, STRIP));
         end
         1: begin
            w = 7'($urandom_range(0, STRIP));
            h = 7'($urandom_range(0, 127));
         end
         default: begin
            w = 7'($urandom_range(0, BLOCK));
            h = 7'($urandom_range(0, BLOCK));
         end
      endcase
   endfunction

   // wait for every result, then let writes drain out of the pipe
   task automatic drain();
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [23:0] d);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = d;
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic set_config(input logic [6:0] w, input logic [6:0] h, input logic wr,
                             input logic [15:0] sc, input logic [23:0] off);
      drain();
      write_reg(CSR_GRID_WIDTH, {17'($urandom), w});
      write_reg(CSR_GRID_HEIGHT, {17'($urandom), h});
      write_reg(CSR_WRAP_MODE, {23'($urandom), wr});
      write_reg(CSR_HEIGHT_SCALE, {8'($urandom), sc});
      write_reg(CSR_HEIGHT_OFFSET, off);
   endtask

   // fill the corner block and the edge strips so no query reads an unwritten entry
   task automatic load_grid();
      for (int r = 0; r < ROWS; r++)
         for (int c = 0; c < COLS; c++)
            if ((r < BLOCK && c < BLOCK) || r < STRIP || c < STRIP)
               write_sample(c, r, (r + c) % 5 == 0 ? 16'h7FFF :
                                  (r + c) % 5 == 1 ? 16'h8000 : 16'($urandom));
   endtask

   task automatic directed_queries();
      logic [23:0] pts [8] = '{24'h000000, 24'h010000, 24'h010001, 24'h7FFFFF,
                               24'h800000, 24'hFFFFFF, 24'h008000, 24'h00FFFF};
      set_config(7'd64, 7'd2, 1'b0, 16'h0100, 24'h0);
      for (int k = 0; k < 8; k++) query_at(pts[k], pts[7 - k]);
      set_config(7'd127, 7'd1, 1'b1, 16'h7FFF, 24'h7FFFFF);
      for (int k = 0; k < 8; k++) query_at(pts[k], pts[(k + 3) % 8]);
      set_config(7'd0, 7'd127, 1'b0, 16'h8000, 24'h800000);
      write_reg(CSR_UNUSED_INDEX, 24'hFFFFFF);
      for (int k = 0; k < 6; k++) query_at(pts[k], pts[k]);
   endtask

   task automatic random_traffic(input int n);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 3) == 0)
            write_sample(int'($urandom_range(0, COLS - 1)), int'($urandom_range(0, ROWS - 1)),
                         16'($urandom));
         else
            query_at(pick_coord(), pick_coord());
      end
   endtask

   task automatic config_sweep();
      logic [6:0] w, h;
      set_config(7'd2, 7'd2, 1'b1, 16'h8000, 24'h800000);
      random_traffic(120);
      set_config(7'd1, 7'd65, 1'b0, 16'h7FFF, 24'h7FFFFF);
      random_traffic(120);
      set_config(7'd64, 7'd0, 1'b1, 16'hFF00, 24'h000100);
      random_traffic(120);
      for (int p = 0; p < 5; p++) begin
         pick_sizes(w, h);
         set_config(w, h, 1'($urandom), 16'($urandom), 24'($urandom));
         random_traffic(120);
      end
   endtask

   task automatic pause_for_results();
      random_traffic(50);
      while (pending_samples.size() != 0) @(posedge clock);
      @(negedge clock);
      random_traffic(50);
   endtask

   task automatic no_idle_stretch();
      set_config(7'd20, 7'd20, 1'b0, 16'h0100, 24'h0);
      send_idle = 0;
      recv_idle = 0;
      random_traffic(300);
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_item = '0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_width = 7'd64;
      cfg_height = 7'd64;
      cfg_wrap = 0;
      cfg_scale = 16'sd256;
      cfg_offset = 24'sd0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;
      load_grid();
      directed_queries();
      config_sweep();
      pause_for_results();
      no_idle_stretch();
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_samples.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

>>> height_grid_bilinear_sampler_unit.f
hw/rtl/hgbs_pkg.sv
hw/rtl/hgbs_bank.sv
hw/rtl/hgbs_locate.sv
hw/rtl/hgbs_interp.sv
hw/rtl/height_grid_bilinear_sampler_unit.sv
bench/height_grid_bilinear_sampler_unit_test.sv
